@@ hdl/rgbpwm_pkg.sv @@
// Package for the RGB LED PWM fade controller.
// Holds the command codes, the item structs and the fixed widths.
// No dependencies.
package rgbpwm_pkg;

  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned DIV_W    = 7;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_FADE = 2'd2,
    CMD_WAVE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] step_delay;
  } in_item_t;

  typedef struct packed {
    logic                red_on;
    logic                green_on;
    logic                blue_on;
    logic                fading;
    logic [COLOUR_W-1:0] red_level;
    logic [COLOUR_W-1:0] green_level;
    logic [COLOUR_W-1:0] blue_level;
  } out_item_t;

endpackage

@@ hdl/rgb_led_pwm_fade_controller_unit.sv @@
// RGB LED PWM fade controller, top level: input register, state update, result register.
// Depends on rgbpwm_pkg.
//
// An item accepted into the input register is processed by the combinational update and its
// result is latched in the result register once that register is free. Throughput: one item
// per cycle, set by the single combinational update between the input register and the
// result register; the input stalls only while a result waits for out_ready_i.
// Reset: rst_ni clears every colour, duty, counter, direction and drive bit at once.
module rgb_led_pwm_fade_controller_unit
  import rgbpwm_pkg::*;
#(
  parameter int unsigned TICK_DIVIDE = 82,
  parameter int unsigned PWM_BITS    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [DIV_W-1:0]    DIV_LAST   = DIV_W'(TICK_DIVIDE);
  localparam logic [PWM_BITS-1:0] PHASE_FULL = {PWM_BITS{1'b1}};

  // Input stage.
  logic     in_valid_q;
  in_item_t in_q;

  // Result stage.
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Block state.
  logic [COLOUR_W-1:0] colour_q [NUM_CH];
  logic [COLOUR_W-1:0] colour_d [NUM_CH];
  logic [COLOUR_W-1:0] duty_q   [NUM_CH];
  logic [COLOUR_W-1:0] duty_d   [NUM_CH];
  logic [COLOUR_W-1:0] target_q [NUM_CH];
  logic [COLOUR_W-1:0] target_d [NUM_CH];
  logic [NUM_CH-1:0]   rising_q, rising_d;
  logic [NUM_CH-1:0]   drive_q, drive_d;
  logic [PWM_BITS-1:0] phase_q, phase_d;
  logic [DIV_W-1:0]    div_q, div_d;
  logic [COLOUR_W-1:0] delay_cnt_q, delay_cnt_d;
  logic [COLOUR_W-1:0] fade_delay_q, fade_delay_d;
  logic                fade_active_q, fade_active_d;

  logic out_free;
  logic advance;

  // Handshake: the result register frees when empty or being taken; the input
  // register frees when it moves on.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  // Next state for the item in the input register.
  always_comb begin
    logic [COLOUR_W-1:0] rgb       [NUM_CH];
    logic [COLOUR_W-1:0] chk_tgt   [NUM_CH];
    logic [COLOUR_W-1:0] shifted;
    logic [PWM_BITS-1:0] duty_s;
    logic [DIV_W-1:0]    div_inc;
    logic [COLOUR_W-1:0] dly_after;
    logic [COLOUR_W-1:0] chk_delay;
    logic                chk_en;
    logic                done;

    rgb[0] = in_q.red;
    rgb[1] = in_q.green;
    rgb[2] = in_q.blue;

    colour_d      = colour_q;
    duty_d        = duty_q;
    target_d      = target_q;
    rising_d      = rising_q;
    drive_d       = drive_q;
    phase_d       = phase_q;
    div_d         = div_q;
    delay_cnt_d   = delay_cnt_q;
    fade_delay_d  = fade_delay_q;
    fade_active_d = fade_active_q;

    chk_tgt   = target_q;
    chk_delay = fade_delay_q;
    chk_en    = 1'b0;
    shifted   = '0;
    duty_s    = '0;
    div_inc   = div_q + 1'b1;
    dly_after = delay_cnt_q;

    case (in_q.cmd)
      CMD_TICK: begin
        // Advance the phase; at the wrap latch duties, drive nonzero channels; else drop finished ones.
        phase_d = phase_q + 1'b1;
        for (int k = 0; k < NUM_CH; k++) begin
          if (phase_d == '0) begin
            duty_d[k] = colour_q[k];
            shifted   = colour_q[k] >> (COLOUR_W - PWM_BITS);
            duty_s    = shifted[PWM_BITS-1:0];
            if (duty_s != '0) begin
              drive_d[k] = 1'b1;
            end
          end else begin
            shifted = duty_q[k] >> (COLOUR_W - PWM_BITS);
            duty_s  = shifted[PWM_BITS-1:0];
            if (phase_d >= duty_s && duty_s != PHASE_FULL) begin
              drive_d[k] = 1'b0;
            end
          end
        end
        // Divided tick counts the fade wait down, saturating at zero.
        if (div_inc >= DIV_LAST) begin
          div_d = '0;
          if (delay_cnt_q != '0) begin
            dly_after = delay_cnt_q - 1'b1;
          end
        end else begin
          div_d = div_inc;
        end
        delay_cnt_d = dly_after;
        chk_en      = fade_active_q && (dly_after == '0);
      end
      CMD_SET: begin
        colour_d      = rgb;
        fade_active_d = 1'b0;
      end
      CMD_FADE: begin
        target_d     = rgb;
        fade_delay_d = in_q.step_delay;
        chk_tgt      = rgb;
        chk_delay    = in_q.step_delay;
        chk_en       = 1'b1;
      end
      CMD_WAVE: begin
        // Ramp step: each channel counts up or down with wrap-around and reverses when it lands on zero.
        for (int k = 0; k < NUM_CH; k++) begin
          if (rising_q[k]) begin
            colour_d[k] = colour_q[k] + 1'b1;
            if (colour_d[k] == '0) begin
              rising_d[k] = 1'b0;
            end
          end else begin
            colour_d[k] = colour_q[k] - 1'b1;
            if (colour_d[k] == '0) begin
              rising_d[k] = 1'b1;
            end
          end
        end
        fade_active_d = 1'b0;
      end
      default: begin
        fade_active_d = fade_active_q;
      end
    endcase

    // Fade check: end when all targets are reached, else step once and reload the wait.
    done = 1'b1;
    for (int k = 0; k < NUM_CH; k++) begin
      if (colour_q[k] != chk_tgt[k]) begin
        done = 1'b0;
      end
    end
    if (chk_en) begin
      if (done) begin
        fade_active_d = 1'b0;
      end else begin
        for (int k = 0; k < NUM_CH; k++) begin
          if (colour_q[k] < chk_tgt[k]) begin
            colour_d[k] = colour_q[k] + 1'b1;
          end else if (colour_q[k] > chk_tgt[k]) begin
            colour_d[k] = colour_q[k] - 1'b1;
          end
        end
        delay_cnt_d   = chk_delay;
        fade_active_d = 1'b1;
      end
    end

    out_d.red_on      = drive_d[0];
    out_d.green_on    = drive_d[1];
    out_d.blue_on     = drive_d[2];
    out_d.fading      = fade_active_d;
    out_d.red_level   = colour_d[0];
    out_d.green_level = colour_d[1];
    out_d.blue_level  = colour_d[2];
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      rising_q      <= '0;
      drive_q       <= '0;
      phase_q       <= '0;
      div_q         <= '0;
      delay_cnt_q   <= '0;
      fade_delay_q  <= '0;
      fade_active_q <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        colour_q[k] <= '0;
        duty_q[k]   <= '0;
        target_q[k] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        colour_q      <= colour_d;
        duty_q        <= duty_d;
        target_q      <= target_d;
        rising_q      <= rising_d;
        drive_q       <= drive_d;
        phase_q       <= phase_d;
        div_q         <= div_d;
        delay_cnt_q   <= delay_cnt_d;
        fade_delay_q  <= fade_delay_d;
        fade_active_q <= fade_active_d;
      end
    end
  end

  // Payload registers: load on handshake, no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // Divider never reaches its terminal count between ticks.
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q < DIV_LAST)
    else $error("tick divider out of range");

  // A set or wave item always leaves the fade cancelled.
  a_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.cmd == CMD_SET || in_q.cmd == CMD_WAVE) |=> !fade_active_q)
    else $error("fade survived a set or wave item");

  // Only a tick may change the LED drives.
  a_drive_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.cmd != CMD_TICK |=> drive_q == $past(drive_q))
    else $error("drive changed on a non-tick item");

  // Back pressure on the input only while a result waits.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with a free result register");
`endif

endmodule
